// ===== rtl/pac_pkg.sv =====
// ---------------------------------------------------------------------------
// pac_pkg: shared types and constants for the point axis colormap
// Storage sizes, queue entry layout, back end states and the color lookup.
// ---------------------------------------------------------------------------
package pac_pkg;

  localparam int MAX_POINTS  = 1024;
  localparam int COORD_WIDTH = 32;
  localparam int IN_WIDTH    = 32;
  localparam int EXT_WIDTH   = 48;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int NUM_W       = COORD_WIDTH + 9;
  localparam int DV_W        = COORD_WIDTH + 1;
  localparam int DVS_W       = DV_W + 7;
  localparam int LEVEL_W     = 8;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int LEVEL_K     = 510;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_SELECT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MAP   = 1'd1;

  // Axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Color map codes
  localparam logic [2:0] CMAP_BLUE_RED     = 3'd0;
  localparam logic [2:0] CMAP_GREEN_MAG    = 3'd1;
  localparam logic [2:0] CMAP_WHITE_RED    = 3'd2;
  localparam logic [2:0] CMAP_GREY_RED     = 3'd3;
  localparam logic [2:0] CMAP_RAINBOW      = 3'd4;

  // Request codes
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_READOUT = 1'b1;

  localparam logic [LEVEL_W-1:0] LEVEL_MID = 8'd128;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t coord;
    coord_t lo;
    coord_t hi;
    logic   last;
  } pac_entry_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PREP,
    B_MULT,
    B_DIV,
    B_DONE
  } back_state_t;

  // Sign-extend a 32-bit input field, then keep COORD_WIDTH bits
  function automatic coord_t to_coord(logic [IN_WIDTH-1:0] raw);
    logic [EXT_WIDTH-1:0] ext;
    ext = {{(EXT_WIDTH - IN_WIDTH){raw[IN_WIDTH-1]}}, raw};
    return coord_t'(ext[COORD_WIDTH-1:0]);
  endfunction

  function automatic rgb_t color_lookup(logic [LEVEL_W-1:0] v, logic [2:0] cmap);
    rgb_t       c;
    logic [7:0] dbl;
    dbl = {v[6:0], 1'b0};
    case (cmap)
      CMAP_BLUE_RED: begin
        c = '{red: v, green: 8'd0, blue: LEVEL_MAX - v};
      end
      CMAP_GREEN_MAG: begin
        c = '{red: v, green: LEVEL_MAX - v, blue: v};
      end
      CMAP_WHITE_RED: begin
        c = '{red: LEVEL_MAX, green: LEVEL_MAX - v, blue: LEVEL_MAX - v};
      end
      CMAP_GREY_RED: begin
        if (v > LEVEL_MID) c = '{red: LEVEL_MAX, green: 8'd0, blue: 8'd0};
        else               c = '{red: LEVEL_MID, green: LEVEL_MID, blue: LEVEL_MID};
      end
      default: begin
        // rainbow; dbl is 2v below the midpoint and 2(v-128) above it
        c.red   = (v > LEVEL_MID) ? dbl : 8'd0;
        c.green = (v < LEVEL_MID) ? dbl : LEVEL_MAX - dbl;
        c.blue  = (v < LEVEL_MID) ? LEVEL_MAX - dbl : 8'd0;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/pac_ifs.sv =====
// ---------------------------------------------------------------------------
// pac_ifs: channel interfaces for the point axis colormap
// Valid/ready channels for requests, colored results and register writes.
// ---------------------------------------------------------------------------
interface pac_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] coord_x;
  logic [31:0] coord_y;
  logic [31:0] coord_z;

  modport source (output valid, req_type, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, req_type, coord_x, coord_y, coord_z, output ready);
endinterface

interface pac_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] level;
  logic       last_point;

  modport source (output valid, red, green, blue, level, last_point, input ready);
  modport sink   (input valid, red, green, blue, level, last_point, output ready);
endinterface

interface pac_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/pac_front.sv =====
// ---------------------------------------------------------------------------
// pac_front: request intake and point store
// Stores loads, tracks min/max and count, and queues readouts with a snapshot.
// ---------------------------------------------------------------------------
module pac_front
  import pac_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  pac_in_if.sink       in_ch,
  input  logic [1:0]   axis_sel,
  input  logic         q_full,
  output logic         q_push,
  output pac_entry_t   q_entry
);

  coord_t             mem [MAX_POINTS];
  coord_t             rdata_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   ridx_r, ridx_nxt;
  coord_t             lo_r, lo_nxt;
  coord_t             hi_r, hi_nxt;
  logic               pend_r, pend_nxt;
  coord_t             snap_lo_r, snap_hi_r;
  logic               snap_last_r;

  logic               accept, do_load, do_read, last_rd;
  logic [IN_WIDTH-1:0] raw;
  coord_t             cval;

  assign in_ch.ready = !pend_r && !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign do_load     = accept && (in_ch.req_type == REQ_LOAD) &&
                       (count_r != CNT_W'(MAX_POINTS));
  assign do_read     = accept && (in_ch.req_type == REQ_READOUT) &&
                       (count_r != '0);
  assign last_rd     = (ridx_r + CNT_W'(1)) == count_r;

  always_comb begin
    case (axis_sel)
      AXIS_X:  raw = in_ch.coord_x;
      AXIS_Y:  raw = in_ch.coord_y;
      default: raw = in_ch.coord_z;
    endcase
    cval = to_coord(raw);
  end

  always_comb begin
    count_nxt = count_r;
    ridx_nxt  = ridx_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    pend_nxt  = 1'b0;
    if (do_load) begin
      count_nxt = count_r + CNT_W'(1);
      if (count_r == '0) begin
        lo_nxt = cval;
        hi_nxt = cval;
      end else begin
        if (cval < lo_r) lo_nxt = cval;
        if (cval > hi_r) hi_nxt = cval;
      end
    end
    if (do_read) begin
      pend_nxt = 1'b1;
      if (last_rd) begin
        // final point: empty the store
        count_nxt = '0;
        ridx_nxt  = '0;
        lo_nxt    = '0;
        hi_nxt    = '0;
      end else begin
        ridx_nxt = ridx_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ridx_r  <= '0;
      lo_r    <= '0;
      hi_r    <= '0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ridx_r  <= ridx_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) mem[count_r[IDX_W-1:0]] <= cval;
    if (do_read) begin
      rdata_r     <= mem[ridx_r[IDX_W-1:0]];
      snap_lo_r   <= lo_r;
      snap_hi_r   <= hi_r;
      snap_last_r <= last_rd;
    end
  end

  assign q_push  = pend_r;
  assign q_entry = '{coord: rdata_r, lo: snap_lo_r, hi: snap_hi_r, last: snap_last_r};

endmodule

// ===== rtl/pac_queue.sv =====
// ---------------------------------------------------------------------------
// pac_queue: readout queue between front and back
// Small FIFO of readout entries so either side can stall on its own.
// ---------------------------------------------------------------------------
module pac_queue
  import pac_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  pac_entry_t push_entry,
  input  logic       pop,
  output pac_entry_t pop_entry,
  output logic       full,
  output logic       empty
);

  pac_entry_t          slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [Q_PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [Q_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full    = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt = do_push ? wptr_r + Q_PTR_W'(1) : wptr_r;
    rptr_nxt = do_pop  ? rptr_r + Q_PTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + Q_CNT_W'(1);
    if (do_pop && !do_push) cnt_nxt = cnt_r - Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wptr_r] <= push_entry;
  end

  assign pop_entry = slot_r[rptr_r];

endmodule

// ===== rtl/pac_back.sv =====
// ---------------------------------------------------------------------------
// pac_back: level computation and color lookup
// Normalizes one queued coordinate with a bit-serial divider, then colors it.
// ---------------------------------------------------------------------------
module pac_back
  import pac_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [2:0] cmap,
  input  logic       q_empty,
  input  pac_entry_t q_entry,
  output logic       q_pop,
  pac_out_if.source  out_ch
);

  back_state_t               state_r, state_nxt;
  pac_entry_t                ent_r;
  logic [COORD_WIDTH-1:0]    d_r, span_r;
  logic                      flat_r;
  logic [NUM_W-1:0]          num_r;
  logic [DVS_W-1:0]          dvs_r;
  logic [2:0]                step_r;
  logic [LEVEL_W-1:0]        quo_r;
  logic                      out_valid_r;
  rgb_t                      out_rgb_r;
  logic [LEVEL_W-1:0]        out_level_r;
  logic                      out_last_r;

  logic signed [DIFF_W-1:0]  diff, span_s;
  logic [NUM_W-1:0]          num_calc;
  logic                      ge;
  logic                      out_free;
  logic                      ld_ent, ld_prep, ld_mult, ld_div, ld_out;
  logic [LEVEL_W-1:0]        level_fin;

  assign diff     = DIFF_W'(ent_r.coord) - DIFF_W'(ent_r.lo);
  assign span_s   = DIFF_W'(ent_r.hi) - DIFF_W'(ent_r.lo);
  assign num_calc = NUM_W'(d_r) * NUM_W'(LEVEL_K) + NUM_W'(span_r);
  assign ge       = num_r >= NUM_W'(dvs_r);
  assign out_free = !out_valid_r || out_ch.ready;
  assign level_fin = flat_r ? '0 : quo_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (!q_empty) state_nxt = B_PREP;
      B_PREP: state_nxt = B_MULT;
      B_MULT: state_nxt = B_DIV;
      B_DIV:  if (step_r == 3'd7) state_nxt = B_DONE;
      B_DONE: if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    ld_ent  = 1'b0;
    ld_prep = 1'b0;
    ld_mult = 1'b0;
    ld_div  = 1'b0;
    ld_out  = 1'b0;
    case (state_r)
      B_IDLE: ld_ent  = !q_empty;
      B_PREP: ld_prep = 1'b1;
      B_MULT: ld_mult = 1'b1;
      B_DIV:  ld_div  = 1'b1;
      B_DONE: ld_out  = out_free;
      default: ;
    endcase
  end

  assign q_pop = ld_ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ld_out)            out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_ent) ent_r <= q_entry;
    if (ld_prep) begin
      // clamp the offset into [0, span]; a flat range forces level 0
      if (diff <= 0)                         d_r <= '0;
      else if (diff > span_s)                d_r <= span_s[COORD_WIDTH-1:0];
      else                                   d_r <= diff[COORD_WIDTH-1:0];
      span_r <= span_s[COORD_WIDTH-1:0];
      flat_r <= span_s <= 0;
    end
    if (ld_mult) begin
      num_r  <= num_calc;
      dvs_r  <= {span_r, 1'b0, 7'b0};
      step_r <= '0;
    end
    if (ld_div) begin
      // one quotient bit per cycle, most significant first
      if (ge) num_r <= num_r - NUM_W'(dvs_r);
      dvs_r  <= dvs_r >> 1;
      quo_r  <= {quo_r[LEVEL_W-2:0], ge};
      step_r <= step_r + 3'd1;
    end
    if (ld_out) begin
      out_rgb_r   <= color_lookup(level_fin, cmap);
      out_level_r <= level_fin;
      out_last_r  <= ent_r.last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.red        = out_rgb_r.red;
  assign out_ch.green      = out_rgb_r.green;
  assign out_ch.blue       = out_rgb_r.blue;
  assign out_ch.level      = out_level_r;
  assign out_ch.last_point = out_last_r;

endmodule

// ===== rtl/point_axis_colormap.sv =====
// ---------------------------------------------------------------------------
// point_axis_colormap: min/max normalized colormap over one point axis
// Top level: register file, point store front end, queue and color back end.
// ---------------------------------------------------------------------------
// A load item (req_type 0) stores the coordinate on the selected axis in a
// 1024-entry on-chip memory and updates the running min/max; it is dropped
// once the store is full. A readout item (req_type 1) passes through the
// front end (memory read, then queueing with a snapshot of min/max) and
// the back end, where an 8-step bit-serial divider forms the level
// round(255*(c-min)/(max-min)); the back end takes a new readout only once
// it is through with the last one. A two-entry queue decouples the two ends
// and an output register holds the finished result, so loads and up to three
// new readouts (one in the back end, two in the queue) keep flowing while a
// result waits; once the queue is full the request channel stalls, loads
// included. The final readout sets last_point and empties the store. A
// readout of an empty store yields no result. Register writes are taken at
// once.
module point_axis_colormap
  import pac_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  pac_in_if.sink     in_ch,
  pac_out_if.source  out_ch,
  pac_cfg_if.sink    cfg_ch
);

  logic [1:0]  axis_sel_r;
  logic [2:0]  cmap_r;
  logic        q_full, q_empty, q_push, q_pop;
  pac_entry_t  push_entry, pop_entry;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_sel_r <= AXIS_Y;
      cmap_r     <= CMAP_RAINBOW;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_AXIS_SELECT: axis_sel_r <= cfg_ch.data[1:0];
        REG_COLOR_MAP:   cmap_r     <= cfg_ch.data[2:0];
        default: ;
      endcase
    end
  end

  pac_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .axis_sel (axis_sel_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  pac_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .full       (q_full),
    .empty      (q_empty)
  );

  pac_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmap    (cmap_r),
    .q_empty (q_empty),
    .q_entry (pop_entry),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
